FILE: hdl/btss_pkg.sv
// ----------------------------------------------------------------------------
// btss_pkg
// Shared types, state codes and helpers for the buddy tree state store.
// ----------------------------------------------------------------------------
package btss_pkg;

    // Tree geometry
    localparam int unsigned MaxOrder  = 10;
    localparam int unsigned NodeAw    = MaxOrder + 1;
    localparam int unsigned NodeTotal = (1 << (MaxOrder + 1)) - 1;
    localparam int unsigned OrderW    = 4;
    localparam int unsigned BlockW    = MaxOrder;

    typedef logic [NodeAw-1:0] node_idx_t;
    typedef logic [NodeAw:0]   wide_t;
    typedef logic [OrderW-1:0] order_t;
    typedef logic [BlockW-1:0] block_t;
    typedef logic [1:0]        nstate_t;

    // Node state codes
    localparam nstate_t ST_FREE   = 2'd0;
    localparam nstate_t ST_TAKEN  = 2'd1;
    localparam nstate_t ST_PARTLY = 2'd2;

    // Request modes
    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_DEALLOC = 2'd1,
        MODE_READ    = 2'd2,
        MODE_WRITE   = 2'd3
    } mode_t;

    // One result beat
    typedef struct packed {
        node_idx_t node;
        nstate_t   state;
        order_t    bord;
        block_t    first;
        logic      bud;
        logic      err;
    } btss_result_t;

    // Depth of a node given its index plus one: position of the top set bit
    function automatic order_t node_depth(input node_idx_t v);
        order_t d;
        d = '0;
        for (int i = 0; i < NodeAw; i++) begin
            if (v[i])
            begin
                d = order_t'(i);
            end
        end
        return d;
    endfunction

endpackage

FILE: hdl/btss_ram.sv
// ----------------------------------------------------------------------------
// btss_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module btss_ram #(
    parameter int unsigned Depth = 2047,
    parameter int unsigned AddrW = 11,
    parameter int unsigned DataW = 2
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [DataW-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [DataW-1:0] rd_data
);

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/btss_ctrl.sv
// ----------------------------------------------------------------------------
// btss_ctrl
// Sequencer: clearing sweep, tree climbs, read-modify-write of node states.
// ----------------------------------------------------------------------------
module btss_ctrl
    import btss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   mode,
    input  block_t       block_number,
    input  order_t       alloc_order,
    input  node_idx_t    node_select,
    input  nstate_t      node_value,
    // config
    input  logic         cfg_valid,
    input  order_t       tree_order,
    // result
    output logic         res_valid,
    input  logic         res_ready,
    output btss_result_t res,
    // node memory
    output logic         wr_en,
    output node_idx_t    wr_addr,
    output nstate_t      wr_data,
    output logic         rd_en,
    output node_idx_t    rd_addr,
    input  nstate_t      rd_data
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_CLIMB_RD,
        S_CLIMB_CHK,
        S_ANC_RD,
        S_ANC_CHK,
        S_WR,
        S_DE_RD,
        S_DE_CHK,
        S_RD_SELF,
        S_RD_BUD,
        S_FINISH
    } state_t;

    state_t    state_reg,  state_next;
    mode_t     mode_reg,   mode_next;
    block_t    blk_reg,    blk_next;
    order_t    pw_reg,     pw_next;
    node_idx_t sel_reg,    sel_next;
    nstate_t   val_reg,    val_next;
    order_t    n_reg,      n_next;
    order_t    order_reg,  order_next;
    node_idx_t p_reg,      p_next;
    order_t    h_reg,      h_next;
    node_idx_t node_reg,   node_next;
    node_idx_t top_reg,    top_next;
    nstate_t   st_reg,     st_next;
    order_t    bord_reg,   bord_next;
    block_t    first_reg,  first_next;
    logic      bud_reg,    bud_next;
    logic      err_reg,    err_next;
    node_idx_t clr_reg,    clr_next;

    node_idx_t parent;
    node_idx_t leaf;
    node_idx_t sel_inc;
    node_idx_t buddy;
    order_t    depth;
    order_t    bord_calc;
    wide_t     first_wide;
    logic      blk_big;
    logic      sel_big;

    // Tree arithmetic on the working node and the latched request
    always_comb
    begin
        parent     = (p_reg - node_idx_t'(1)) >> 1;
        leaf       = node_idx_t'(blk_reg) + (node_idx_t'(1) << n_reg) - node_idx_t'(1);
        sel_inc    = sel_reg + node_idx_t'(1);
        buddy      = sel_reg[0] ? sel_reg + node_idx_t'(1) : sel_reg - node_idx_t'(1);
        depth      = node_depth(sel_inc);
        bord_calc  = n_reg - depth;
        first_wide = (wide_t'(sel_inc) << bord_calc) - (wide_t'(1) << n_reg);
        blk_big    = (blk_reg >> n_reg) != '0;
        sel_big    = wide_t'(sel_reg) >= ((wide_t'(1) << (n_reg + order_t'(1))) - wide_t'(1));
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        blk_next   = blk_reg;
        pw_next    = pw_reg;
        sel_next   = sel_reg;
        val_next   = val_reg;
        n_next     = n_reg;
        order_next = order_reg;
        p_next     = p_reg;
        h_next     = h_reg;
        node_next  = node_reg;
        top_next   = top_reg;
        st_next    = st_reg;
        bord_next  = bord_reg;
        first_next = first_reg;
        bud_next   = bud_reg;
        err_next   = err_reg;
        clr_next   = clr_reg;
        rd_en      = 1'b0;
        rd_addr    = p_reg;
        wr_en      = 1'b0;
        wr_addr    = p_reg;
        wr_data    = ST_FREE;
        res_valid  = 1'b0;

        // config register, to be written by the user only while idle; the block does not enforce it
        if (cfg_valid)
        begin
            order_next = tree_order;
        end

        unique case (state_reg)
            // sweep every node to free after reset
            S_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + node_idx_t'(1);
                if (clr_reg == node_idx_t'(NodeTotal - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode_t'(mode);
                    blk_next   = block_number;
                    pw_next    = alloc_order;
                    sel_next   = node_select;
                    val_next   = node_value;
                    n_next     = (order_reg > order_t'(MaxOrder)) ? order_t'(MaxOrder)
                                                                  : order_reg;
                    state_next = S_START;
                end
            end

            // precondition checks and first access
            S_START:
            begin
                err_next   = 1'b0;
                node_next  = '0;
                st_next    = ST_FREE;
                bord_next  = '0;
                first_next = '0;
                bud_next   = 1'b0;
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (blk_big || pw_reg > n_reg)
                        begin
                            err_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            p_next = leaf;
                            h_next = '0;
                            if (pw_reg == '0)
                            begin
                                node_next  = leaf;
                                top_next   = leaf;
                                state_next = S_ANC_RD;
                            end
                            else
                            begin
                                state_next = S_CLIMB_RD;
                            end
                        end
                    end
                    MODE_DEALLOC:
                    begin
                        if (blk_big)
                        begin
                            err_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            p_next     = leaf;
                            state_next = S_DE_RD;
                        end
                    end
                    MODE_READ:
                    begin
                        if (sel_big)
                        begin
                            err_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = sel_reg;
                            node_next  = sel_reg;
                            bord_next  = bord_calc;
                            first_next = first_wide[BlockW-1:0];
                            state_next = S_RD_SELF;
                        end
                    end
                    MODE_WRITE:
                    begin
                        if (sel_big || val_reg > ST_PARTLY)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = sel_reg;
                            wr_data   = val_reg;
                            node_next = sel_reg;
                            st_next   = val_reg;
                        end
                        state_next = S_FINISH;
                    end
                endcase
            end

            // alloc: nodes on the leaf path below the target must be free
            S_CLIMB_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_CLIMB_CHK;
            end

            S_CLIMB_CHK:
            begin
                if (rd_data != ST_FREE)
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    p_next = parent;
                    h_next = h_reg + order_t'(1);
                    if (h_reg + order_t'(1) == pw_reg)
                    begin
                        node_next  = parent;
                        top_next   = parent;
                        state_next = S_ANC_RD;
                    end
                    else
                    begin
                        state_next = S_CLIMB_RD;
                    end
                end
            end

            // alloc: ancestors up to the first partly free one
            S_ANC_RD:
            begin
                if (p_reg == '0)
                begin
                    p_next     = node_reg;
                    state_next = S_WR;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    p_next     = parent;
                    state_next = S_ANC_CHK;
                end
            end

            S_ANC_CHK:
            begin
                if (rd_data == ST_TAKEN)
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (rd_data == ST_PARTLY)
                begin
                    p_next     = node_reg;
                    state_next = S_WR;
                end
                else
                begin
                    top_next   = p_reg;
                    state_next = S_ANC_RD;
                end
            end

            // alloc: mark target taken, free ancestors partly free
            S_WR:
            begin
                wr_en   = 1'b1;
                wr_data = (p_reg == node_reg) ? ST_TAKEN : ST_PARTLY;
                if (p_reg == top_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    p_next = parent;
                end
            end

            // dealloc: climb to the first taken node
            S_DE_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DE_CHK;
            end

            S_DE_CHK:
            begin
                if (rd_data == ST_TAKEN)
                begin
                    wr_en      = 1'b1;
                    wr_data    = ST_FREE;
                    node_next  = p_reg;
                    state_next = S_FINISH;
                end
                else if (rd_data == ST_FREE && p_reg != '0)
                begin
                    p_next     = parent;
                    state_next = S_DE_RD;
                end
                else
                begin
                    err_next   = 1'b1;
                    state_next = S_FINISH;
                end
            end

            // read: node, then its sibling unless the node is the root
            S_RD_SELF:
            begin
                st_next = rd_data;
                if (sel_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = buddy;
                    state_next = S_RD_BUD;
                end
            end

            S_RD_BUD:
            begin
                bud_next   = (rd_data == ST_FREE);
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            order_reg <= order_t'(MaxOrder);
            clr_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            order_reg <= order_next;
            clr_reg   <= clr_next;
            err_reg   <= err_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        blk_reg   <= blk_next;
        pw_reg    <= pw_next;
        sel_reg   <= sel_next;
        val_reg   <= val_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        h_reg     <= h_next;
        node_reg  <= node_next;
        top_reg   <= top_next;
        st_reg    <= st_next;
        bord_reg  <= bord_next;
        first_reg <= first_next;
        bud_reg   <= bud_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    // Error beats carry zero in every other field
    always_comb
    begin
        res.err   = err_reg;
        res.node  = err_reg ? '0 : node_reg;
        res.state = err_reg ? ST_FREE : st_reg;
        res.bord  = err_reg ? '0 : bord_reg;
        res.first = err_reg ? '0 : first_reg;
        res.bud   = err_reg ? 1'b0 : bud_reg;
    end

    // Every memory read is consumed by a check state
    a_rd_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == S_CLIMB_CHK || state_reg == S_ANC_CHK ||
                   state_reg == S_DE_CHK || state_reg == S_RD_SELF ||
                   state_reg == S_RD_BUD))
        else $error("btss_ctrl: read data not consumed");

    // Alloc write pass marks only the target node taken
    a_taken_target: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && wr_data == ST_TAKEN) |-> (p_reg == node_reg))
        else $error("btss_ctrl: taken written off target");

    // No write beyond the last node
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != node_idx_t'(NodeTotal)))
        else $error("btss_ctrl: write address out of range");

    // A delivered result returns the sequencer to idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_ready) |=> (state_reg == S_IDLE))
        else $error("btss_ctrl: no return to idle after result");

endmodule

FILE: hdl/btss_out.sv
// ----------------------------------------------------------------------------
// btss_out
// Output register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module btss_out
    import btss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    output logic         res_ready,
    input  btss_result_t res,
    output logic         out_valid,
    input  logic         out_stall,
    output btss_result_t out_res
);

    logic         out_valid_reg;
    btss_result_t res_reg;

    // Slot is free when empty or being emptied this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: hdl/buddy_tree_state_store_unit.sv
// ----------------------------------------------------------------------------
// buddy_tree_state_store_unit
// Node-state store of a buddy allocator bitmap tree (free/taken/partly free).
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall) carries one request beat: alloc,
//   dealloc, read node or write node. Result channel (out_valid/out_stall)
//   returns exactly one beat per request. Config channel (cfg_valid/
//   cfg_ready) writes tree_order; ready is always high, write only when idle.
//   One request is worked at a time; node states live in a 2047 x 2 RAM
//   with a registered read port, so each tree level costs a RAM access.
//   Each request is worked through to its result: write and requests
//   rejected up front go straight to the result, read reads the node and,
//   off the root, its sibling, dealloc reads one node per level climbed,
//   alloc reads the nodes it checks and then writes the target and the
//   ancestors it marks. The next request is taken in the cycle after the
//   result moves into the output register, so the levels walked set the
//   item spacing. After reset the RAM is swept to free, one node per cycle,
//   with in_stall high; config writes are still taken.
//   A finished result sits in an output register; while out_stall is high
//   it holds and the sequencer waits with its next result, stalling input.
// ----------------------------------------------------------------------------
module buddy_tree_state_store_unit
    import btss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // request
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [1:0] mode,
    input  block_t    block_number,
    input  order_t    alloc_order,
    input  node_idx_t node_select,
    input  nstate_t   node_value,
    // config
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  order_t    tree_order,
    // result
    output logic      out_valid,
    input  logic      out_stall,
    output node_idx_t result_node,
    output nstate_t   node_state,
    output order_t    block_order,
    output block_t    first_block,
    output logic      buddy_free,
    output logic      error
);

    logic         res_valid;
    logic         res_ready;
    btss_result_t res;
    btss_result_t out_res;
    logic         wr_en;
    node_idx_t    wr_addr;
    nstate_t      wr_data;
    logic         rd_en;
    node_idx_t    rd_addr;
    nstate_t      rd_data;

    assign cfg_ready = 1'b1;

    // Sequencer
    btss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .block_number (block_number),
        .alloc_order  (alloc_order),
        .node_select  (node_select),
        .node_value   (node_value),
        .cfg_valid    (cfg_valid),
        .tree_order   (tree_order),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    // Node state memory
    btss_ram #(
        .Depth (NodeTotal),
        .AddrW (NodeAw),
        .DataW (2)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result register
    btss_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign result_node = out_res.node;
    assign node_state  = out_res.state;
    assign block_order = out_res.bord;
    assign first_block = out_res.first;
    assign buddy_free  = out_res.bud;
    assign error       = out_res.err;

endmodule
